/* rtl/hafp_pkg.sv */
// ----------------------------------------------------------------------------
// hafp_pkg
// Shared types and codes for the hex ASCII frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hafp_pkg;

    localparam int unsigned KindW  = 3;
    localparam int unsigned FieldW = 2;

    typedef logic [KindW-1:0]  kind_t;
    typedef logic [FieldW-1:0] field_t;

    localparam kind_t K_HEADER   = 3'd0;
    localparam kind_t K_PAYLOAD  = 3'd1;
    localparam kind_t K_COMPLETE = 3'd2;
    localparam kind_t K_BADMARK  = 3'd3;
    localparam kind_t K_TOOLONG  = 3'd4;
    localparam kind_t K_TRUNC    = 3'd5;

    localparam field_t F_APP   = 2'd0;
    localparam field_t F_LOGIC = 2'd1;
    localparam field_t F_ITEM  = 2'd2;

    // One result beat
    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        field_t      field;
        logic [7:0]  item_index;
        logic [7:0]  flow_id;
        logic        last_of_run;
    } result_t;

    // Results produced by one input byte (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        result_t    res_a;
        result_t    res_b;
    } result_pair_t;

endpackage : hafp_pkg

`default_nettype wire

/* rtl/hafp_core.sv */
// ----------------------------------------------------------------------------
// hafp_core
// Parser state and the per-byte update; yields up to two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hafp_core
    import hafp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         first_of_buffer,
    input  wire logic         last_of_buffer,
    input  wire logic [31:0]  buffer_length,
    output result_pair_t      results
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_MARK, PH_FLOW, PH_TOTAL, PH_APPLEN, PH_APPBYTES,
        PH_LOGLEN, PH_LOGBYTES, PH_COUNT, PH_ITEMLEN, PH_ITEMBYTES, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [31:0] acc_reg, acc_next;
    logic        stopped_reg, stopped_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  items_left_reg, items_left_next;
    logic [7:0]  cur_item_reg, cur_item_next;
    logic [7:0]  flow_reg, flow_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] buf_len_reg, buf_len_next;

    // Frame state seen by this byte, after a possible restart
    phase_t      ph;
    logic [2:0]  dc;
    logic [31:0] acc;
    logic        stopped;
    logic [31:0] bytes_left;
    logic [7:0]  items_left;
    logic [7:0]  cur_item;

    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [31:0] acc_upd;
    logic [31:0] left_dec;
    logic [7:0]  items_dec;
    logic [2:0]  dc_last;
    logic [1:0]  n;
    result_t     res_a, res_b;

    always_comb
    begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
        begin
            hex_digit = 4'(rx_byte - 8'h30);
        end
        else if (rx_byte >= 8'h41 && rx_byte <= 8'h46)
        begin
            hex_digit = 4'(rx_byte - 8'h37);
        end
        else if (rx_byte >= 8'h61 && rx_byte <= 8'h66)
        begin
            hex_digit = 4'(rx_byte - 8'h57);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        ph         = phase_reg;
        dc         = digit_count_reg;
        acc        = acc_reg;
        stopped    = stopped_reg;
        bytes_left = bytes_left_reg;
        items_left = items_left_reg;
        cur_item   = cur_item_reg;
        flow_next    = flow_reg;
        total_next   = total_reg;
        buf_len_next = buf_len_reg;
        if (first_of_buffer)
        begin
            ph           = PH_MARK;
            dc           = 3'd0;
            acc          = 32'd0;
            stopped      = 1'b0;
            bytes_left   = 32'd0;
            items_left   = 8'd0;
            cur_item     = 8'd0;
            flow_next    = 8'd0;
            total_next   = 32'd0;
            buf_len_next = buffer_length;
        end

        phase_next       = ph;
        digit_count_next = dc;
        acc_next         = acc;
        stopped_next     = stopped;
        bytes_left_next  = bytes_left;
        items_left_next  = items_left;
        cur_item_next    = cur_item;

        n     = 2'd0;
        res_a = '0;
        res_b = '0;

        acc_upd   = (!stopped && hex_ok) ? {acc[27:0], hex_digit} : acc;
        left_dec  = bytes_left - 32'd1;
        items_dec = items_left - 8'd1;
        dc_last   = (ph == PH_TOTAL || ph == PH_ITEMLEN) ? 3'd7 : 3'd1;

        unique case (ph)
            PH_IDLE, PH_DONE:
            begin
            end
            PH_MARK:
            begin
                // Expected mark "A6A6": even positions 'A', odd positions '6'
                if (rx_byte != (dc[0] ? 8'h36 : 8'h41))
                begin
                    phase_next = PH_DONE;
                    n = 2'd1;
                    res_a.kind = K_BADMARK;
                end
                else if (dc >= 3'd3)
                begin
                    digit_count_next = 3'd0;
                    phase_next = PH_FLOW;
                end
                else
                begin
                    digit_count_next = dc + 3'd1;
                end
            end
            PH_APPBYTES, PH_LOGBYTES, PH_ITEMBYTES:
            begin
                n = 2'd1;
                res_a.kind  = K_PAYLOAD;
                res_a.value = {24'd0, rx_byte};
                res_a.field = (ph == PH_APPBYTES) ? F_APP :
                              (ph == PH_LOGBYTES) ? F_LOGIC : F_ITEM;
                res_a.item_index = (ph == PH_ITEMBYTES) ? cur_item : 8'd0;
                bytes_left_next = left_dec;
                if (left_dec == 32'd0)
                begin
                    if (ph == PH_APPBYTES)
                    begin
                        phase_next = PH_LOGLEN;
                    end
                    else if (ph == PH_LOGBYTES)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        items_left_next = items_dec;
                        if (items_dec == 8'd0)
                        begin
                            phase_next = PH_DONE;
                            n = 2'd2;
                            res_b.kind  = K_COMPLETE;
                            res_b.value = total_next;
                        end
                        else
                        begin
                            cur_item_next = cur_item + 8'd1;
                            phase_next = PH_ITEMLEN;
                        end
                    end
                end
            end
            default:
            begin
                // Hex digit slots; accumulate until a non-hex character
                acc_next     = acc_upd;
                stopped_next = stopped | ~hex_ok;
                if (dc == dc_last)
                begin
                    acc_next         = 32'd0;
                    stopped_next     = 1'b0;
                    digit_count_next = 3'd0;
                    priority case (ph)
                        PH_FLOW:
                        begin
                            flow_next  = acc_upd[7:0];
                            phase_next = PH_TOTAL;
                        end
                        PH_TOTAL:
                        begin
                            total_next = acc_upd;
                            if (acc_upd > buf_len_next)
                            begin
                                phase_next = PH_DONE;
                                n = 2'd1;
                                res_a.kind  = K_TOOLONG;
                                res_a.value = acc_upd;
                            end
                            else
                            begin
                                phase_next = PH_APPLEN;
                            end
                        end
                        PH_APPLEN, PH_LOGLEN:
                        begin
                            n = 2'd1;
                            res_a.kind  = K_HEADER;
                            res_a.value = acc_upd;
                            res_a.field = (ph == PH_APPLEN) ? F_APP : F_LOGIC;
                            bytes_left_next = acc_upd;
                            if (ph == PH_APPLEN)
                            begin
                                phase_next = (acc_upd == 32'd0) ? PH_LOGLEN : PH_APPBYTES;
                            end
                            else
                            begin
                                phase_next = (acc_upd == 32'd0) ? PH_COUNT : PH_LOGBYTES;
                            end
                        end
                        PH_COUNT:
                        begin
                            items_left_next = acc_upd[7:0];
                            cur_item_next   = 8'd0;
                            if (acc_upd[7:0] == 8'd0)
                            begin
                                phase_next = PH_DONE;
                                n = 2'd1;
                                res_a.kind  = K_COMPLETE;
                                res_a.value = total_next;
                            end
                            else
                            begin
                                phase_next = PH_ITEMLEN;
                            end
                        end
                        default:
                        begin
                            n = 2'd1;
                            res_a.kind       = K_HEADER;
                            res_a.value      = acc_upd;
                            res_a.field      = F_ITEM;
                            res_a.item_index = cur_item;
                            bytes_left_next  = acc_upd;
                            if (acc_upd == 32'd0)
                            begin
                                items_left_next = items_dec;
                                if (items_dec == 8'd0)
                                begin
                                    phase_next = PH_DONE;
                                    n = 2'd2;
                                    res_b.kind  = K_COMPLETE;
                                    res_b.value = total_next;
                                end
                                else
                                begin
                                    cur_item_next = cur_item + 8'd1;
                                    phase_next = PH_ITEMLEN;
                                end
                            end
                            else
                            begin
                                phase_next = PH_ITEMBYTES;
                            end
                        end
                    endcase
                end
                else
                begin
                    digit_count_next = dc + 3'd1;
                end
            end
        endcase

        // Buffer ended before the frame closed
        if (last_of_buffer && ph != PH_IDLE && ph != PH_DONE && phase_next != PH_DONE)
        begin
            phase_next = PH_DONE;
            if (n == 2'd0)
            begin
                res_a.kind = K_TRUNC;
                n = 2'd1;
            end
            else
            begin
                res_b.kind = K_TRUNC;
                n = 2'd2;
            end
        end

        res_a.flow_id     = flow_next;
        res_b.flow_id     = flow_next;
        res_a.last_of_run = (n == 2'd1);
        res_b.last_of_run = 1'b1;
    end

    assign results.count = step ? n : 2'd0;
    assign results.res_a = res_a;
    assign results.res_b = res_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            digit_count_reg <= 3'd0;
            acc_reg         <= 32'd0;
            stopped_reg     <= 1'b0;
            bytes_left_reg  <= 32'd0;
            items_left_reg  <= 8'd0;
            cur_item_reg    <= 8'd0;
            flow_reg        <= 8'd0;
            total_reg       <= 32'd0;
            buf_len_reg     <= 32'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            acc_reg         <= acc_next;
            stopped_reg     <= stopped_next;
            bytes_left_reg  <= bytes_left_next;
            items_left_reg  <= items_left_next;
            cur_item_reg    <= cur_item_next;
            flow_reg        <= flow_next;
            total_reg       <= total_next;
            buf_len_reg     <= buf_len_next;
        end
    end

endmodule : hafp_core

`default_nettype wire

/* rtl/hafp_out_fifo.sv */
// ----------------------------------------------------------------------------
// hafp_out_fifo
// Four-entry result queue: takes up to two results a cycle, gives one while out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hafp_out_fifo
    import hafp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  result_pair_t      push,
    output logic              has_room,
    output logic              out_valid,
    input  wire logic         out_ready,
    output result_t           out_data
);

    result_t    mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign has_room  = (count_reg <= 3'd2);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res_a;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= push.res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : hafp_out_fifo

`default_nettype wire

/* rtl/hex_ascii_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// hex_ascii_frame_parser_top
// Byte-stream parser for "A6A6"-marked frames with ASCII-hex length fields.
// ----------------------------------------------------------------------------
// Queueing: a byte's results enter the queue on the edge that accepts its
//   beat; with an empty queue the first is on the master side in the cycle after.
// Throughput: one byte per cycle while no byte yields two results and the
//   master does not stall; a byte's second result uses an extra queue slot.
// Reset: asynchronous, active low; parser returns to idle (waiting for a
//   first-of-buffer byte) and the result queue empties.
`default_nettype none

module hex_ascii_frame_parser_top
    import hafp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Byte stream in
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // [7:0] rx_byte, [39:8] buffer_length
    input  wire logic         s_tuser,   // [0] first_of_buffer
    input  wire logic         s_tlast,   // last_of_buffer
    // Results out
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,   // [31:0] value, [33:32] field,
                                         // [41:34] item_index, [49:42] flow_id,
                                         // [55:50] zero
    output logic [2:0]        m_tuser,   // [2:0] kind
    output logic              m_tlast    // last_of_run
);

    logic         room;
    logic         step;
    result_pair_t results;
    result_t      head;

    // Take a beat only while the queue can absorb two results
    assign s_tready = room;
    assign step     = s_tvalid && room;

    // Parser state and per-byte decode; results land in the queue on the
    // same edge that accepts the beat.
    hafp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .rx_byte         (s_tdata[7:0]),
        .first_of_buffer (s_tuser),
        .last_of_buffer  (s_tlast),
        .buffer_length   (s_tdata[39:8]),
        .results         (results)
    );

    // Result queue decouples the two sides so a stalled master does not
    // hold off input until fewer than two queue entries are free.
    hafp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (results),
        .has_room  (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {6'd0, head.flow_id, head.item_index, head.field, head.value};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule : hex_ascii_frame_parser_top

`default_nettype wire
